>>> rtl/ffmc_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ffmc_pkg
// Shared types, codes and constants for the fan and flap mode controller.
// ----------------------------------------------------------------------------
package ffmc_pkg;

   localparam int unsigned SettleW = 22;
   localparam logic [SettleW-1:0] SettleMax = {SettleW{1'b1}};
   localparam logic [SettleW-1:0] SettleTicksReset = 22'd90000;

   localparam int unsigned CsrAddrW = 3;
   localparam int unsigned CsrDataW = 32;
   localparam int unsigned ReqDataW = 8;
   localparam int unsigned RspDataW = 24;

   // command codes
   localparam logic [2:0] CmdSpeed = 3'd0;
   localparam logic [2:0] CmdFan   = 3'd1;
   localparam logic [2:0] CmdMode  = 3'd2;
   localparam logic [2:0] CmdTick  = 3'd3;
   localparam logic [2:0] CmdRelay = 3'd4;

   // mode codes
   localparam logic [1:0] ModeUnknown = 2'd0;
   localparam logic [1:0] ModeSuck    = 2'd1;
   localparam logic [1:0] ModeBlow    = 2'd2;
   localparam logic [1:0] ModePending = 2'd3;

   // fan state values
   localparam logic [1:0] FanOff = 2'd0;
   localparam logic [1:0] FanOn  = 2'd1;

   // relay actions
   localparam logic [1:0] RelayOn     = 2'd0;
   localparam logic [1:0] RelayOff    = 2'd1;
   localparam logic [1:0] RelayToggle = 2'd2;

   // csr register index
   localparam logic [0:0] RegSettleTicks = 1'b0;

   typedef struct packed {
      logic [2:0] command;
      logic [1:0] value;
      logic       relay_index;
   } item_type;

   // first member lands in the top bits
   typedef struct packed {
      logic       relay1_on;
      logic       relay0_on;
      logic [1:0] mode_out;
      logic       blow_flap_open;
      logic       suck_flap_open;
      logic       flaps_moving_out;
      logic       direction_blow;
      logic       fan_on;
      logic [1:0] speed_out;
      logic [7:0] pwm_duty;
   } result_type;

   function automatic logic [7:0] duty_of_level(input logic [1:0] level);
      logic [7:0] duty;
      unique case (level)
         2'd0: duty = 8'd0;
         2'd1: duty = 8'd64;
         2'd2: duty = 8'd128;
         2'd3: duty = 8'd254;
         default: duty = 8'd0;
      endcase
      return duty;
   endfunction

endpackage

>>> rtl/fan_flap_mode_controller.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fan_flap_mode_controller
// Reversible fan, flap and relay controller with an APB settle register.
// ----------------------------------------------------------------------------
//  channel  ports    role     content
//  req      req_*    in       tuser: command[2:0]; tdata: value[1:0], relay_index[2]
//  rsp      rsp_*    out      tdata: pwm_duty .. relay1_on, one per command
//  csr      csr_*    apb      mode_settle_ticks at 0x0
//
//  Each accepted command is held in the input register; the combinational state
//  update runs ahead of the result register, which captures the result on advance.
//  Throughput is one command per cycle while the result is not stalled.
//  Synchronous active-high reset; no clearing pass.
//  A stalled result holds both registers; req_tready drops only then.
// ----------------------------------------------------------------------------
module fan_flap_mode_controller (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               req_tvalid,
   output logic                               req_tready,
   // [0] value[0], [1] value[1], [2] relay_index, [7:3] zero
   input  logic [ffmc_pkg::ReqDataW-1:0]      req_tdata,
   // [2:0] command
   input  logic [2:0]                         req_tuser,
   output logic                               rsp_tvalid,
   input  logic                               rsp_tready,
   // [7:0] pwm_duty, [9:8] speed_out, [10] fan_on, [11] direction_blow,
   // [12] flaps_moving_out, [13] suck_flap_open, [14] blow_flap_open,
   // [16:15] mode_out, [17] relay0_on, [18] relay1_on, [23:19] zero
   output logic [ffmc_pkg::RspDataW-1:0]      rsp_tdata,
   input  logic                               csr_psel,
   input  logic                               csr_penable,
   input  logic                               csr_pwrite,
   input  logic [ffmc_pkg::CsrAddrW-1:0]      csr_paddr,
   input  logic [ffmc_pkg::CsrDataW-1:0]      csr_pwdata,
   output logic [ffmc_pkg::CsrDataW-1:0]      csr_prdata,
   output logic                               csr_pready
);

   localparam int unsigned ResultW = $bits(ffmc_pkg::result_type);

   logic                          in_valid_ff, in_valid_in;
   ffmc_pkg::item_type            item_ff, item_in;
   logic                          rsp_valid_ff, rsp_valid_in;
   ffmc_pkg::result_type          rsp_data_ff, rsp_data_in;
   ffmc_pkg::result_type          result;
   logic                          advance;
   logic                          req_fire;
   logic [ffmc_pkg::SettleW-1:0]  settle_ticks;

   ffmc_csr u_csr (
      .clock        (clock),
      .reset        (reset),
      .csr_psel     (csr_psel),
      .csr_penable  (csr_penable),
      .csr_pwrite   (csr_pwrite),
      .csr_paddr    (csr_paddr),
      .csr_pwdata   (csr_pwdata),
      .csr_prdata   (csr_prdata),
      .csr_pready   (csr_pready),
      .settle_ticks (settle_ticks)
   );

   ffmc_core u_core (
      .clock        (clock),
      .reset        (reset),
      .advance      (advance),
      .item         (item_ff),
      .settle_ticks (settle_ticks),
      .result       (result)
   );

   assign advance    = in_valid_ff && (!rsp_valid_ff || rsp_tready);
   assign req_tready = !in_valid_ff || advance;
   assign req_fire   = req_tvalid && req_tready;

   always_comb begin
      in_valid_in = in_valid_ff;
      item_in     = item_ff;
      if (req_fire) begin
         in_valid_in       = 1'b1;
         item_in.command     = req_tuser;
         item_in.value       = req_tdata[1:0];
         item_in.relay_index = req_tdata[2];
      end else if (advance) begin
         in_valid_in = 1'b0;
      end
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      rsp_data_in  = rsp_data_ff;
      if (advance) begin
         rsp_valid_in = 1'b1;
         rsp_data_in  = result;
      end else if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         in_valid_ff  <= in_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      item_ff     <= item_in;
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {{(ffmc_pkg::RspDataW - ResultW){1'b0}}, rsp_data_ff};

   // a running fan needs a settled mode
   a_fan_needs_settled: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && rsp_data_ff.fan_on |->
         (rsp_data_ff.mode_out == ffmc_pkg::ModeSuck ||
          rsp_data_ff.mode_out == ffmc_pkg::ModeBlow))
      else $error("fan on while mode not settled");

   // direction follows the mode while running
   a_dir_follows_mode: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && rsp_data_ff.fan_on |->
         (rsp_data_ff.direction_blow == (rsp_data_ff.mode_out == ffmc_pkg::ModeBlow)))
      else $error("fan direction disagrees with mode");

   // flap motors run exactly while the mode is pending
   a_flaps_pending: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |->
         (rsp_data_ff.flaps_moving_out == (rsp_data_ff.mode_out == ffmc_pkg::ModePending)))
      else $error("flap motion out of step with mode");

   // a held command is not dropped
   a_item_held: assert property (@(posedge clock) disable iff (reset)
      in_valid_ff && !advance |=> in_valid_ff && $stable(item_ff))
      else $error("stalled command lost");

endmodule

>>> rtl/ffmc_csr.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ffmc_csr
// APB register file holding the mode settle tick count.
// ----------------------------------------------------------------------------
module ffmc_csr (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               csr_psel,
   input  logic                               csr_penable,
   input  logic                               csr_pwrite,
   input  logic [ffmc_pkg::CsrAddrW-1:0]      csr_paddr,
   input  logic [ffmc_pkg::CsrDataW-1:0]      csr_pwdata,
   output logic [ffmc_pkg::CsrDataW-1:0]      csr_prdata,
   output logic                               csr_pready,
   output logic [ffmc_pkg::SettleW-1:0]       settle_ticks
);

   logic [ffmc_pkg::SettleW-1:0] settle_ticks_ff;
   logic [ffmc_pkg::SettleW-1:0] settle_ticks_in;
   logic                         hit;
   logic                         wr_en;

   assign csr_pready = 1'b1;
   assign hit   = (csr_paddr[ffmc_pkg::CsrAddrW-1:2] == ffmc_pkg::RegSettleTicks);
   assign wr_en = csr_psel && csr_penable && csr_pwrite && csr_pready && hit;

   assign settle_ticks_in = wr_en ? csr_pwdata[ffmc_pkg::SettleW-1:0] : settle_ticks_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         settle_ticks_ff <= ffmc_pkg::SettleTicksReset;
      end else begin
         settle_ticks_ff <= settle_ticks_in;
      end
   end

   always_comb begin
      csr_prdata = '0;
      if (hit) begin
         csr_prdata[ffmc_pkg::SettleW-1:0] = settle_ticks_ff;
      end
   end

   assign settle_ticks = settle_ticks_ff;

endmodule

>>> rtl/ffmc_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ffmc_core
// Controller state and its combinational update for one command.
// ----------------------------------------------------------------------------
module ffmc_core (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          advance,
   input  ffmc_pkg::item_type            item,
   input  logic [ffmc_pkg::SettleW-1:0]  settle_ticks,
   output ffmc_pkg::result_type          result
);

   logic [1:0]                   mode_ff, mode_in;
   logic [1:0]                   target_ff, target_in;
   logic [ffmc_pkg::SettleW-1:0] count_ff, count_in;
   logic [ffmc_pkg::SettleW-1:0] count_inc;
   logic [1:0]                   speed_ff, speed_in;
   logic                         fan_ff, fan_in;
   logic                         dir_blow_ff, dir_blow_in;
   logic                         moving_ff, moving_in;
   logic                         suck_ff, suck_in;
   logic                         blow_ff, blow_in;
   logic [1:0]                   relay_ff, relay_in;

   assign count_inc = (count_ff != ffmc_pkg::SettleMax) ?
                      count_ff + 1'b1 : count_ff;

   always_comb begin
      mode_in     = mode_ff;
      target_in   = target_ff;
      count_in    = count_ff;
      speed_in    = speed_ff;
      fan_in      = fan_ff;
      dir_blow_in = dir_blow_ff;
      moving_in   = moving_ff;
      suck_in     = suck_ff;
      blow_in     = blow_ff;
      relay_in    = relay_ff;
      unique case (item.command)
         ffmc_pkg::CmdSpeed: begin
            speed_in = item.value;
            if (item.value == 2'd0 && fan_ff) begin
               fan_in      = 1'b0;
               dir_blow_in = 1'b1;
            end
         end
         ffmc_pkg::CmdFan: begin
            if (item.value == ffmc_pkg::FanOn) begin
               if (!fan_ff) begin
                  if (mode_ff == ffmc_pkg::ModeSuck || mode_ff == ffmc_pkg::ModeBlow) begin
                     dir_blow_in = (mode_ff == ffmc_pkg::ModeBlow);
                     fan_in      = 1'b1;
                  end else begin
                     dir_blow_in = 1'b1;
                  end
               end
            end else if (item.value == ffmc_pkg::FanOff && fan_ff) begin
               fan_in      = 1'b0;
               dir_blow_in = 1'b1;
            end
         end
         ffmc_pkg::CmdMode: begin
            if ((item.value == ffmc_pkg::ModeSuck || item.value == ffmc_pkg::ModeBlow)
                && mode_ff != item.value) begin
               mode_in   = ffmc_pkg::ModePending;
               target_in = item.value;
               if (fan_ff) begin
                  fan_in      = 1'b0;
                  dir_blow_in = 1'b1;
               end
               suck_in   = (item.value == ffmc_pkg::ModeSuck);
               blow_in   = (item.value == ffmc_pkg::ModeBlow);
               moving_in = 1'b1;
               count_in  = '0;
            end
         end
         ffmc_pkg::CmdTick: begin
            if (target_ff != mode_ff) begin
               if (count_inc >= settle_ticks) begin
                  mode_in   = target_ff;
                  count_in  = '0;
                  moving_in = 1'b0;
                  suck_in   = 1'b0;
                  blow_in   = 1'b0;
               end else begin
                  count_in = count_inc;
               end
            end
         end
         ffmc_pkg::CmdRelay: begin
            unique case (item.value)
               ffmc_pkg::RelayOn:     relay_in[item.relay_index] = 1'b1;
               ffmc_pkg::RelayOff:    relay_in[item.relay_index] = 1'b0;
               ffmc_pkg::RelayToggle: relay_in[item.relay_index] = !relay_ff[item.relay_index];
               default: ;
            endcase
         end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff     <= ffmc_pkg::ModePending;
         target_ff   <= ffmc_pkg::ModeSuck;
         count_ff    <= '0;
         speed_ff    <= 2'd1;
         fan_ff      <= 1'b0;
         dir_blow_ff <= 1'b1;
         moving_ff   <= 1'b1;
         suck_ff     <= 1'b1;
         blow_ff     <= 1'b0;
         relay_ff    <= '0;
      end else if (advance) begin
         mode_ff     <= mode_in;
         target_ff   <= target_in;
         count_ff    <= count_in;
         speed_ff    <= speed_in;
         fan_ff      <= fan_in;
         dir_blow_ff <= dir_blow_in;
         moving_ff   <= moving_in;
         suck_ff     <= suck_in;
         blow_ff     <= blow_in;
         relay_ff    <= relay_in;
      end
   end

   always_comb begin
      result.pwm_duty         = ffmc_pkg::duty_of_level(speed_in);
      result.speed_out        = speed_in;
      result.fan_on           = fan_in;
      result.direction_blow   = dir_blow_in;
      result.flaps_moving_out = moving_in;
      result.suck_flap_open   = suck_in;
      result.blow_flap_open   = blow_in;
      result.mode_out         = mode_in;
      result.relay0_on        = relay_in[0];
      result.relay1_on        = relay_in[1];
   end

endmodule
